// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by range_max_point_update.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked every clock outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rmpu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmpu_pkg
// Types, sizes and helpers for the range maximum / point update tree block.
// ----------------------------------------------------------------------------
package rmpu_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int NODE_COUNT   = 2 * MAX_ELEMENTS;
	localparam int NODE_W       = $clog2(NODE_COUNT);
	localparam int WALK_W       = NODE_W + 1;

	localparam int VALUE_W = 31;
	localparam int POS_W   = 11;
	localparam int COUNT_W = 11;

	// input word layout, lowest bit first
	localparam int POS_LSB   = 0;
	localparam int VAL_LSB   = POS_LSB + POS_W;
	localparam int LEFT_LSB  = VAL_LSB + VALUE_W;
	localparam int RIGHT_LSB = LEFT_LSB + POS_W;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 32;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_QRY,
		ST_DRAIN,
		ST_OUT
	} rmpu_state_t;

	function automatic logic [VALUE_W-1:0] max_val(
		input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== hdl/range_max_point_update.sv =====
// ----------------------------------------------------------------------------
// range_max_point_update
// Max segment tree held in one node memory: point updates, range max queries.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: tuser = action (0 update, 1 query), tdata packs
//   position, new_value, range_left, range_right. Updates give no word out;
//   each query gives one word on m_axis_* with the range maximum (0 if the
//   clipped range is empty). cfg_wr_en/cfg_wr_data set element_count; write
//   it only while the block is idle.
//   One item is handled at a time. An update writes the leaf, then at each
//   tree level reads the sibling and writes the parent. A query clips the
//   range, walks the two bounds up the tree (two reads per level from the
//   node memory), sees the bounds meet, drains the compare pipeline and
//   loads the output.
//   After reset the node memory is swept to zero, one node per cycle, with
//   s_axis_tready low. The result waits in an output register; while it
//   stalls, updates keep going, and a following query holds in its final
//   state until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module range_max_point_update
	import rmpu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [COUNT_W-1:0]    cfg_wr_data,      // element_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [10:0] position, [41:11] new_value, [52:42] range_left, [63:53] range_right
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,     // [0] action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata      // [30:0] max_value, [31] zero
);

	rmpu_state_t state_q, state_d;

	logic [NODE_W-1:0]  clr_addr_q;
	logic [COUNT_W-1:0] count_q;
	logic [NODE_W-1:0]  node_q;
	logic [VALUE_W-1:0] cur_q;
	logic [WALK_W-1:0]  a_q, b_q;
	logic               vld_s1, use0_s1, use1_s1;
	logic               pair_vld_s2;
	logic [VALUE_W-1:0] pair_s2;
	logic [VALUE_W-1:0] best_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_data_q;

	logic [VALUE_W-1:0] tree_mem [NODE_COUNT];
	logic [VALUE_W-1:0] rd0_q, rd1_q;

	// fields
	logic               in_action;
	logic [POS_W-1:0]   in_pos, in_left, in_right;
	logic [VALUE_W-1:0] in_value;

	assign in_action = s_axis_tuser;
	assign in_pos    = s_axis_tdata[POS_LSB +: POS_W];
	assign in_value  = s_axis_tdata[VAL_LSB +: VALUE_W];
	assign in_left   = s_axis_tdata[LEFT_LSB +: POS_W];
	assign in_right  = s_axis_tdata[RIGHT_LSB +: POS_W];

	logic               accept;
	logic [COUNT_W-1:0] count_eff;
	logic               upd_ok;
	logic [NODE_W-1:0]  leaf;
	logic [POS_W-1:0]   left_c, right_c;
	logic               q_empty;
	logic [WALK_W-1:0]  a_init, b_init;
	logic [WALK_W-1:0]  b_dec, a_next, b_next;
	logic               walk_more;
	logic [NODE_W-1:0]  parent;
	logic [VALUE_W-1:0] parent_val;
	logic               parent_root;
	logic               clr_last;
	logic               out_free;

	// control outputs
	logic               mem_we;
	logic [NODE_W-1:0]  mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [NODE_W-1:0]  rd0_addr, rd1_addr;
	logic               upd_start, upd_step, qry_start, qry_step, out_load;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign count_eff = (32'(count_q) > MAX_ELEMENTS) ? COUNT_W'(MAX_ELEMENTS) : count_q;
	assign upd_ok    = (in_pos != '0) && (COUNT_W'(in_pos) <= count_eff);
	assign leaf      = NODE_W'(MAX_ELEMENTS) + NODE_W'(in_pos - POS_W'(1));

	assign left_c  = (in_left == '0) ? POS_W'(1) : in_left;
	assign right_c = (COUNT_W'(in_right) > count_eff) ? POS_W'(count_eff) : in_right;
	assign q_empty = left_c > right_c;
	// empty range: start with a == b so the walk ends at once
	assign a_init  = q_empty ? '0 : WALK_W'(MAX_ELEMENTS) + WALK_W'(left_c) - WALK_W'(1);
	assign b_init  = q_empty ? '0 : WALK_W'(MAX_ELEMENTS) + WALK_W'(right_c);

	assign walk_more = a_q < b_q;
	assign b_dec     = b_q - WALK_W'(1);
	assign a_next    = (a_q + WALK_W'(a_q[0])) >> 1;
	assign b_next    = (b_q - WALK_W'(b_q[0])) >> 1;

	// rd0_q holds the sibling of node_q during the update walk
	assign parent      = node_q >> 1;
	assign parent_val  = max_val(cur_q, rd0_q);
	assign parent_root = parent == NODE_W'(1);

	assign clr_last = clr_addr_q == NODE_W'(NODE_COUNT - 1);
	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_action == ACT_QUERY) state_d = ST_QRY;
					else if (upd_ok)            state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (parent_root) state_d = ST_IDLE;
			end
			ST_QRY: begin
				if (!walk_more) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!vld_s1 && !pair_vld_s2) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = '0;
		rd0_addr      = '0;
		rd1_addr      = '0;
		upd_start     = 1'b0;
		upd_step      = 1'b0;
		qry_start     = 1'b0;
		qry_step      = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept && in_action == ACT_QUERY) begin
					qry_start = 1'b1;
				end else if (accept && upd_ok) begin
					upd_start = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = leaf;
					mem_wdata = in_value;
					rd0_addr  = {leaf[NODE_W-1:1], ~leaf[0]};
				end
			end
			ST_UPD: begin
				upd_step  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = parent_val;
				rd0_addr  = {parent[NODE_W-1:1], ~parent[0]};
			end
			ST_QRY: begin
				if (walk_more) begin
					qry_step = 1'b1;
					rd0_addr = a_q[NODE_W-1:0];
					rd1_addr = b_dec[NODE_W-1:0];
				end
			end
			ST_DRAIN: begin
			end
			ST_OUT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// node memory, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) tree_mem[mem_waddr] <= mem_wdata;
		rd0_q <= tree_mem[rd0_addr];
		rd1_q <= tree_mem[rd1_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			count_q     <= COUNT_W'(1024);
			vld_s1      <= 1'b0;
			pair_vld_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + NODE_W'(1);
			if (cfg_wr_en) count_q <= cfg_wr_data;
			vld_s1      <= qry_step;
			pair_vld_s2 <= vld_s1;
			if (out_load)           out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (upd_start) begin
			node_q <= leaf;
			cur_q  <= in_value;
		end else if (upd_step) begin
			node_q <= parent;
			cur_q  <= parent_val;
		end
		if (qry_start) begin
			a_q <= a_init;
			b_q <= b_init;
		end else if (qry_step) begin
			a_q <= a_next;
			b_q <= b_next;
		end
		use0_s1 <= a_q[0];
		use1_s1 <= b_q[0];
		pair_s2 <= max_val(use0_s1 ? rd0_q : '0, use1_s1 ? rd1_q : '0);
		if (qry_start)        best_q <= '0;
		else if (pair_vld_s2) best_q <= max_val(best_q, pair_s2);
		if (out_load) out_data_q <= best_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W){1'b0}}, out_data_q};

	// the tree must not change while a query walks it
	`ASSERT_IMPL(a_no_wr_in_qry, (state_q == ST_QRY || state_q == ST_DRAIN), !mem_we, "node write during query")
	// during the update walk node_q stays below the root
	`ASSERT_IMPL(a_upd_node, state_q == ST_UPD, node_q[NODE_W-1:1] != '0, "update walk past root")
	// the result is loaded only once the compare pipeline is empty
	`ASSERT_IMPL(a_out_drained, state_q == ST_OUT, !vld_s1 && !pair_vld_s2, "result loaded early")
	// a new result word follows only from the output state
	`ASSERT_IMPL(a_out_src, $rose(m_axis_tvalid), $past(state_q) == ST_OUT, "result word from nowhere")

endmodule
